@@ src/wshc_pkg.sv @@
package wshc_pkg;

    localparam int POS_W = 16;
    localparam int LIM_W = 15;
    localparam int BORDER_W = 8;

    localparam int WD = 36;

    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = LIM_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int DIV_BITS = 32;
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_BITS / 2 - 1);

    localparam int CFG_REGS = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_ADDR_W = CFG_IDX_W + 2;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ASP_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ASP_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ASP_X = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ASP_Y = 3'd7;

    typedef logic [1:0] div_op_t;
    localparam div_op_t OP_QUO_W = 2'd0;
    localparam div_op_t OP_QUO_H = 2'd1;
    localparam div_op_t OP_MOD_W = 2'd2;
    localparam div_op_t OP_MOD_H = 2'd3;

    localparam logic signed [WD-1:0] WD_ONE = WD'(1);

    function automatic logic signed [WD-1:0] ext_u15(input logic [LIM_W-1:0] v);
        return signed'(WD'(v));
    endfunction

    function automatic logic signed [WD-1:0] ext_s16(input logic signed [POS_W-1:0] v);
        return WD'(v);
    endfunction

endpackage

@@ src/wshc_if.sv @@
interface wshc_req_if;
    import wshc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [POS_W-1:0]    req_x;
    logic signed [POS_W-1:0]    req_y;
    logic signed [POS_W-1:0]    req_w;
    logic signed [POS_W-1:0]    req_h;
    logic                       apply_hints;
    logic [LIM_W-1:0]           step_w;
    logic [LIM_W-1:0]           step_h;
    logic [LIM_W-1:0]           lower_w;
    logic [LIM_W-1:0]           lower_h;
    logic [LIM_W-1:0]           upper_w;
    logic [LIM_W-1:0]           upper_h;
    logic [BORDER_W-1:0]        frame_border;

    modport source
    (
        output valid, req_x, req_y, req_w, req_h, apply_hints, step_w, step_h,
               lower_w, lower_h, upper_w, upper_h, frame_border,
        input  ready
    );

    modport sink
    (
        input  valid, req_x, req_y, req_w, req_h, apply_hints, step_w, step_h,
               lower_w, lower_h, upper_w, upper_h, frame_border,
        output ready
    );
endinterface

interface wshc_rsp_if;
    import wshc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [POS_W-1:0]    out_x;
    logic signed [POS_W-1:0]    out_y;
    logic signed [POS_W-1:0]    out_w;
    logic signed [POS_W-1:0]    out_h;
    logic                       rejected;
    logic                       changed;

    modport source
    (
        output valid, out_x, out_y, out_w, out_h, rejected, changed,
        input  ready
    );

    modport sink
    (
        input  valid, out_x, out_y, out_w, out_h, rejected, changed,
        output ready
    );
endinterface

@@ src/window_size_hint_constrain.sv @@
// Constrains one requested window geometry by its size hints and the screen
// bounds, keeps the last committed geometry and reports whether it changed.
// The aspect rule needs one division when it clips the size, and each
// nonzero increment needs one. A rejected item skips the position steps.
// When the maximum ratio clips, the minimum ratio compare is skipped. The
// single radix-4 divider does every division, and one 17x16 multiplier
// serves the aspect compares. A new item is accepted as soon as the
// previous one has reached the output register, even while its result
// waits there. An item whose result is ready waits in its last step for
// as long as the previous result is held off.
module window_size_hint_constrain #(
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    wshc_req_if.sink                            req,
    wshc_rsp_if.source                          rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wshc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [wshc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wshc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import wshc_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_PREP    = 5'd1;
    localparam logic [4:0] S_MUL_A   = 5'd2;
    localparam logic [4:0] S_MUL_B   = 5'd3;
    localparam logic [4:0] S_CMP_MAX = 5'd4;
    localparam logic [4:0] S_MUL_C   = 5'd5;
    localparam logic [4:0] S_MUL_D   = 5'd6;
    localparam logic [4:0] S_CMP_MIN = 5'd7;
    localparam logic [4:0] S_DIV     = 5'd8;
    localparam logic [4:0] S_MOD_W   = 5'd9;
    localparam logic [4:0] S_MOD_H   = 5'd10;
    localparam logic [4:0] S_FIN_ADD = 5'd11;
    localparam logic [4:0] S_FIN_MIN = 5'd12;
    localparam logic [4:0] S_FIN_MAX = 5'd13;
    localparam logic [4:0] S_CHECK   = 5'd14;
    localparam logic [4:0] S_POS2    = 5'd15;
    localparam logic [4:0] S_SAT     = 5'd16;
    localparam logic [4:0] S_DONE    = 5'd17;

    function automatic logic signed [WD-1:0] sat_coord(input logic signed [WD-1:0] v);
        logic signed [WD-1:0] hi;
        logic signed [WD-1:0] lo;
        hi = signed'(WD'({(COORD_BITS-1){1'b1}}));
        lo = ~hi;
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    // Control state.
    logic [4:0]                 state_reg, state_next;
    logic                       out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0]      cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]      cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0]      cur_w_reg, cur_w_next;
    logic [COORD_BITS-1:0]      cur_h_reg, cur_h_next;
    logic [LIM_W-1:0]           cfg_reg [CFG_REGS];
    logic [LIM_W-1:0]           cfg_next [CFG_REGS];

    // Working registers.
    logic signed [WD-1:0]       x_reg, x_next;
    logic signed [WD-1:0]       y_reg, y_next;
    logic signed [WD-1:0]       w_reg, w_next;
    logic signed [WD-1:0]       h_reg, h_next;
    logic signed [WD-1:0]       prod_a_reg, prod_a_next;
    logic signed [WD-1:0]       prod_b_reg, prod_b_next;
    logic                       hints_reg, hints_next;
    logic [LIM_W-1:0]           step_w_reg, step_w_next;
    logic [LIM_W-1:0]           step_h_reg, step_h_next;
    logic [LIM_W-1:0]           lower_w_reg, lower_w_next;
    logic [LIM_W-1:0]           lower_h_reg, lower_h_next;
    logic [LIM_W-1:0]           upper_w_reg, upper_w_next;
    logic [LIM_W-1:0]           upper_h_reg, upper_h_next;
    logic [BORDER_W-1:0]        border_reg, border_next;
    logic                       rej_reg, rej_next;

    logic [DIV_BITS-1:0]        div_q_reg, div_q_next;
    logic [LIM_W-1:0]           div_r_reg, div_r_next;
    logic [LIM_W-1:0]           div_den_reg, div_den_next;
    logic [DIV_CNT_W-1:0]       div_cnt_reg, div_cnt_next;
    logic                       div_neg_reg, div_neg_next;
    div_op_t                    div_op_reg, div_op_next;

    logic signed [POS_W-1:0]    out_x_reg, out_x_next;
    logic signed [POS_W-1:0]    out_y_reg, out_y_next;
    logic signed [POS_W-1:0]    out_w_reg, out_w_next;
    logic signed [POS_W-1:0]    out_h_reg, out_h_next;
    logic                       rejected_reg, rejected_next;
    logic                       changed_reg, changed_next;

    // Shared multiplier.
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  mul_p;

    // Shared divider, two quotient bits per cycle.
    logic [LIM_W:0]             r1, r1s, r2, r2s;
    logic                       ge1, ge2;
    logic [DIV_BITS-1:0]        q1, q2;
    logic signed [WD-1:0]       q_mag, quo, rem_mag;

    logic                       cfg_we;
    logic                       aspect_en;
    logic signed [WD-1:0]       sw_e, sh_e, bw_e, bh_e, b2_e;

    assign mul_p = mul_a * mul_b;

    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = APB_DATA_W'(cfg_reg[paddr[CFG_ADDR_W-1:2]]);

    assign aspect_en = (cfg_reg[REG_MIN_ASP_X] != '0) && (cfg_reg[REG_MIN_ASP_Y] != '0)
                    && (cfg_reg[REG_MAX_ASP_X] != '0) && (cfg_reg[REG_MAX_ASP_Y] != '0);

    assign sw_e = ext_u15(cfg_reg[REG_SCREEN_W]);
    assign sh_e = ext_u15(cfg_reg[REG_SCREEN_H]);
    assign bw_e = ext_u15(cfg_reg[REG_BASE_W]);
    assign bh_e = ext_u15(cfg_reg[REG_BASE_H]);
    assign b2_e = signed'(WD'({border_reg, 1'b0}));

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.out_x = out_x_reg;
    assign rsp.out_y = out_y_reg;
    assign rsp.out_w = out_w_reg;
    assign rsp.out_h = out_h_reg;
    assign rsp.rejected = rejected_reg;
    assign rsp.changed = changed_reg;

    always_comb
    begin
        r1 = {div_r_reg, div_q_reg[DIV_BITS-1]};
        ge1 = (r1 >= {1'b0, div_den_reg});
        r1s = ge1 ? (r1 - {1'b0, div_den_reg}) : r1;
        q1 = {div_q_reg[DIV_BITS-2:0], ge1};
        r2 = {r1s[LIM_W-1:0], q1[DIV_BITS-1]};
        ge2 = (r2 >= {1'b0, div_den_reg});
        r2s = ge2 ? (r2 - {1'b0, div_den_reg}) : r2;
        q2 = {q1[DIV_BITS-2:0], ge2};
        q_mag = signed'(WD'(q2));
        quo = div_neg_reg ? -q_mag : q_mag;
        rem_mag = signed'(WD'(r2s[LIM_W-1:0]));
    end

    always_comb
    begin
        logic                   div_start;
        logic signed [WD-1:0]   div_num;
        logic signed [WD-1:0]   div_abs;
        logic [LIM_W-1:0]       div_den_in;
        div_op_t                div_op_in;
        logic signed [WD-1:0]   w_lo;
        logic signed [WD-1:0]   h_lo;
        logic                   differ;

        state_next = state_reg;
        out_valid_next = out_valid_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        cur_w_next = cur_w_reg;
        cur_h_next = cur_h_reg;
        cfg_next = cfg_reg;
        x_next = x_reg;
        y_next = y_reg;
        w_next = w_reg;
        h_next = h_reg;
        prod_a_next = prod_a_reg;
        prod_b_next = prod_b_reg;
        hints_next = hints_reg;
        step_w_next = step_w_reg;
        step_h_next = step_h_reg;
        lower_w_next = lower_w_reg;
        lower_h_next = lower_h_reg;
        upper_w_next = upper_w_reg;
        upper_h_next = upper_h_reg;
        border_next = border_reg;
        rej_next = rej_reg;
        div_q_next = div_q_reg;
        div_r_next = div_r_reg;
        div_den_next = div_den_reg;
        div_cnt_next = div_cnt_reg;
        div_neg_next = div_neg_reg;
        div_op_next = div_op_reg;
        out_x_next = out_x_reg;
        out_y_next = out_y_reg;
        out_w_next = out_w_reg;
        out_h_next = out_h_reg;
        rejected_next = rejected_reg;
        changed_next = changed_reg;

        mul_a = w_reg[MUL_A_W-1:0];
        mul_b = signed'({1'b0, cfg_reg[REG_MAX_ASP_Y]});
        div_start = 1'b0;
        div_num = w_reg;
        div_den_in = step_w_reg;
        div_op_in = OP_MOD_W;
        w_lo = (w_reg < WD_ONE) ? WD_ONE : w_reg;
        h_lo = (h_reg < WD_ONE) ? WD_ONE : h_reg;
        differ = (x_reg[COORD_BITS-1:0] != cur_x_reg) || (y_reg[COORD_BITS-1:0] != cur_y_reg)
              || (w_reg[COORD_BITS-1:0] != cur_w_reg) || (h_reg[COORD_BITS-1:0] != cur_h_reg);

        if (cfg_we)
        begin
            cfg_next[paddr[CFG_ADDR_W-1:2]] = pwdata[LIM_W-1:0];
        end

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    x_next = ext_s16(req.req_x);
                    y_next = ext_s16(req.req_y);
                    w_next = ext_s16(req.req_w);
                    h_next = ext_s16(req.req_h);
                    hints_next = req.apply_hints;
                    step_w_next = req.step_w;
                    step_h_next = req.step_h;
                    lower_w_next = req.lower_w;
                    lower_h_next = req.lower_h;
                    upper_w_next = req.upper_w;
                    upper_h_next = req.upper_h;
                    border_next = req.frame_border;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (hints_reg)
                begin
                    w_next = w_lo - bw_e;
                    h_next = h_lo - bh_e;
                    state_next = aspect_en ? S_MUL_A : S_MOD_W;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_MUL_A:
            begin
                prod_a_next = WD'(mul_p);
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                mul_a = h_reg[MUL_A_W-1:0];
                mul_b = signed'({1'b0, cfg_reg[REG_MAX_ASP_X]});
                prod_b_next = WD'(mul_p);
                state_next = S_CMP_MAX;
            end
            S_CMP_MAX:
            begin
                if (prod_a_reg > prod_b_reg)
                begin
                    div_start = 1'b1;
                    div_num = prod_b_reg;
                    div_den_in = cfg_reg[REG_MAX_ASP_Y];
                    div_op_in = OP_QUO_W;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_MUL_C;
                end
            end
            S_MUL_C:
            begin
                mul_b = signed'({1'b0, cfg_reg[REG_MIN_ASP_Y]});
                prod_a_next = WD'(mul_p);
                state_next = S_MUL_D;
            end
            S_MUL_D:
            begin
                mul_a = h_reg[MUL_A_W-1:0];
                mul_b = signed'({1'b0, cfg_reg[REG_MIN_ASP_X]});
                prod_b_next = WD'(mul_p);
                state_next = S_CMP_MIN;
            end
            S_CMP_MIN:
            begin
                if (prod_a_reg < prod_b_reg)
                begin
                    div_start = 1'b1;
                    div_num = prod_a_reg;
                    div_den_in = cfg_reg[REG_MIN_ASP_X];
                    div_op_in = OP_QUO_H;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_MOD_W;
                end
            end
            S_DIV:
            begin
                div_q_next = q2;
                div_r_next = r2s[LIM_W-1:0];
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    unique case (div_op_reg)
                        OP_QUO_W:
                        begin
                            w_next = quo;
                            state_next = S_MOD_W;
                        end
                        OP_QUO_H:
                        begin
                            h_next = quo;
                            state_next = S_MOD_W;
                        end
                        OP_MOD_W:
                        begin
                            w_next = div_neg_reg ? (w_reg + rem_mag) : (w_reg - rem_mag);
                            state_next = S_MOD_H;
                        end
                        OP_MOD_H:
                        begin
                            h_next = div_neg_reg ? (h_reg + rem_mag) : (h_reg - rem_mag);
                            state_next = S_FIN_ADD;
                        end
                    endcase
                end
            end
            S_MOD_W:
            begin
                if (step_w_reg != '0)
                begin
                    div_start = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_MOD_H;
                end
            end
            S_MOD_H:
            begin
                if (step_h_reg != '0)
                begin
                    div_start = 1'b1;
                    div_num = h_reg;
                    div_den_in = step_h_reg;
                    div_op_in = OP_MOD_H;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_FIN_ADD;
                end
            end
            S_FIN_ADD:
            begin
                w_next = w_reg + bw_e;
                h_next = h_reg + bh_e;
                state_next = S_FIN_MIN;
            end
            S_FIN_MIN:
            begin
                if ((lower_w_reg != '0) && (w_reg < ext_u15(lower_w_reg)))
                begin
                    w_next = ext_u15(lower_w_reg);
                end
                if ((lower_h_reg != '0) && (h_reg < ext_u15(lower_h_reg)))
                begin
                    h_next = ext_u15(lower_h_reg);
                end
                state_next = S_FIN_MAX;
            end
            S_FIN_MAX:
            begin
                if ((upper_w_reg != '0) && (w_reg > ext_u15(upper_w_reg)))
                begin
                    w_next = ext_u15(upper_w_reg);
                end
                if ((upper_h_reg != '0) && (h_reg > ext_u15(upper_h_reg)))
                begin
                    h_next = ext_u15(upper_h_reg);
                end
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if ((w_reg <= 0) || (h_reg <= 0))
                begin
                    rej_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rej_next = 1'b0;
                    if (x_reg > sw_e)
                    begin
                        x_next = sw_e - w_reg - b2_e;
                    end
                    if (y_reg > sh_e)
                    begin
                        y_next = sh_e - h_reg - b2_e;
                    end
                    state_next = S_POS2;
                end
            end
            S_POS2:
            begin
                if (x_reg + w_reg + b2_e < 0)
                begin
                    x_next = '0;
                end
                if (y_reg + h_reg + b2_e < 0)
                begin
                    y_next = '0;
                end
                state_next = S_SAT;
            end
            S_SAT:
            begin
                x_next = sat_coord(x_reg);
                y_next = sat_coord(y_reg);
                w_next = sat_coord(w_reg);
                h_next = sat_coord(h_reg);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    rejected_next = rej_reg;
                    if (rej_reg)
                    begin
                        out_x_next = POS_W'(cur_x_reg);
                        out_y_next = POS_W'(cur_y_reg);
                        out_w_next = POS_W'(cur_w_reg);
                        out_h_next = POS_W'(cur_h_reg);
                        changed_next = 1'b0;
                    end
                    else
                    begin
                        out_x_next = POS_W'(x_reg[COORD_BITS-1:0]);
                        out_y_next = POS_W'(y_reg[COORD_BITS-1:0]);
                        out_w_next = POS_W'(w_reg[COORD_BITS-1:0]);
                        out_h_next = POS_W'(h_reg[COORD_BITS-1:0]);
                        changed_next = differ;
                        cur_x_next = x_reg[COORD_BITS-1:0];
                        cur_y_next = y_reg[COORD_BITS-1:0];
                        cur_w_next = w_reg[COORD_BITS-1:0];
                        cur_h_next = h_reg[COORD_BITS-1:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        div_abs = (div_num < 0) ? -div_num : div_num;
        if (div_start)
        begin
            div_neg_next = (div_num < 0);
            div_q_next = div_abs[DIV_BITS-1:0];
            div_r_next = '0;
            div_den_next = div_den_in;
            div_cnt_next = '0;
            div_op_next = div_op_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            cur_w_reg <= '0;
            cur_h_reg <= '0;
            for (int i = 0; i < CFG_REGS; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            cur_w_reg <= cur_w_next;
            cur_h_reg <= cur_h_next;
            cfg_reg <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        w_reg <= w_next;
        h_reg <= h_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        hints_reg <= hints_next;
        step_w_reg <= step_w_next;
        step_h_reg <= step_h_next;
        lower_w_reg <= lower_w_next;
        lower_h_reg <= lower_h_next;
        upper_w_reg <= upper_w_next;
        upper_h_reg <= upper_h_next;
        border_reg <= border_next;
        rej_reg <= rej_next;
        div_q_reg <= div_q_next;
        div_r_reg <= div_r_next;
        div_den_reg <= div_den_next;
        div_cnt_reg <= div_cnt_next;
        div_neg_reg <= div_neg_next;
        div_op_reg <= div_op_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        out_w_reg <= out_w_next;
        out_h_reg <= out_h_next;
        rejected_reg <= rejected_next;
        changed_reg <= changed_next;
    end

endmodule

@@ src/wshc_checker.sv @@
module wshc_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_ready,
    input  logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  logic [wshc_pkg::POS_W-1:0]  out_x,
    input  logic [wshc_pkg::POS_W-1:0]  out_y,
    input  logic [wshc_pkg::POS_W-1:0]  out_w,
    input  logic [wshc_pkg::POS_W-1:0]  out_h,
    input  logic                        rejected,
    input  logic                        changed
);
    import wshc_pkg::*;

    logic [POS_W-1:0]   last_x_reg, last_x_next;
    logic [POS_W-1:0]   last_y_reg, last_y_next;
    logic [POS_W-1:0]   last_w_reg, last_w_next;
    logic [POS_W-1:0]   last_h_reg, last_h_next;
    logic               rsp_fire;
    logic               same_as_last;

    assign rsp_fire = rsp_valid && rsp_ready;
    assign same_as_last = (out_x == last_x_reg) && (out_y == last_y_reg)
                       && (out_w == last_w_reg) && (out_h == last_h_reg);

    // The last committed geometry, as the ports show it.
    always_comb
    begin
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        last_w_next = last_w_reg;
        last_h_next = last_h_reg;
        if (rsp_fire && !rejected)
        begin
            last_x_next = out_x;
            last_y_next = out_y;
            last_w_next = out_w;
            last_h_next = out_h;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg <= '0;
            last_y_reg <= '0;
            last_w_reg <= '0;
            last_h_reg <= '0;
        end
        else
        begin
            last_x_reg <= last_x_next;
            last_y_reg <= last_y_next;
            last_w_reg <= last_w_next;
            last_h_reg <= last_h_next;
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("input accepted while the previous item was still in work");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rejected && changed))
        else $error("a rejected item reports a change");

    a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_fire && rejected) |-> same_as_last)
        else $error("a rejected item does not return the stored geometry");

    a_unchanged_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_fire && !rejected && !changed) |-> same_as_last)
        else $error("an unchanged item differs from the stored geometry");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(out_x) && $stable(out_y)
                                       && $stable(out_w) && $stable(out_h)
                                       && $stable(rejected) && $stable(changed)))
        else $error("a stalled item was dropped or altered");

endmodule

bind window_size_hint_constrain wshc_checker u_wshc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .out_x     (rsp.out_x),
    .out_y     (rsp.out_y),
    .out_w     (rsp.out_w),
    .out_h     (rsp.out_h),
    .rejected  (rsp.rejected),
    .changed   (rsp.changed)
);
